[design/lru_key_value_cache_core_macros.svh]
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// checked on every edge once out of reset
`define LKVC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lru cache assertion failed");

// checked on every edge, reset included
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lru cache assertion failed");

`else

`define LKVC_ASSERT(lbl, clk, rst, prop)
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[design/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lru key-value cache package
// sizes, command codes and the types shared by the chain of cells
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int CAP_W         = 5;
   localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
   localparam int EFF_W         = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             clear;
      logic             hit_upd;
      logic             ins_upd;
      logic [KEY_W-1:0] key;
   } cell_ctrl_type;

endpackage

[design/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lru key-value cache cell
// one recency slot: compares its key and takes its upstream neighbor's entry
// ----------------------------------------------------------------------------
module lkvc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_pkg::cell_ctrl_type ctrl_i,
   input  logic                  in_cap_i,
   input  lkvc_pkg::entry_type   prev_i,
   input  logic                  tail_hit_i,
   output lkvc_pkg::entry_type   entry_o,
   output logic                  match_o,
   output logic                  hit_o
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [lkvc_pkg::KEY_W-1:0]   key_ff;
   logic [lkvc_pkg::KEY_W-1:0]   key_in;
   logic [lkvc_pkg::VALUE_W-1:0] value_ff;
   logic [lkvc_pkg::VALUE_W-1:0] value_in;
   logic                         take;

   always_comb begin
      match_o  = valid_ff && (key_ff == ctrl_i.key);
      hit_o    = match_o | tail_hit_i;
      take     = in_cap_i && (ctrl_i.ins_upd || (ctrl_i.hit_upd && hit_o));
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl_i.clear) begin
         valid_in = 1'b0;
      end else if (take) begin
         valid_in = prev_i.valid;
         key_in   = prev_i.key;
         value_in = prev_i.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry_o.valid = valid_ff;
   assign entry_o.key   = key_ff;
   assign entry_o.value = value_ff;

endmodule

[design/lru_key_value_cache_core.sv]
// ----------------------------------------------------------------------------
// lru key-value cache core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// The cache is a row of cells kept in recency order, most recent first. An
// item is accepted whenever the result register is empty or being drained,
// and a get's result appears in that register on the next cycle. The clock
// period is set by the broadcast key compare in every cell and the hit ripple
// that runs back through the chain to choose which cells shift. A put gives
// no result. Writing the capacity register empties the cache; the port is
// always ready and must be written only while idle; the block does not check.
module lru_key_value_cache_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic signed [31:0]         req_key,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic signed [31:0]         rsp_read_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [4:0]                 csr_capacity_in_use
);

   `include "lru_key_value_cache_core_macros.svh"

   localparam int N = lkvc_pkg::CACHE_ENTRIES;

   logic [lkvc_pkg::CAP_W-1:0]   cap_ff;
   logic [lkvc_pkg::CAP_W-1:0]   cap_in;
   logic [lkvc_pkg::EFF_W-1:0]   eff_cap;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_found_ff;
   logic                         rsp_found_in;
   logic [lkvc_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [lkvc_pkg::VALUE_W-1:0] rsp_value_in;

   logic                         req_acc;
   logic                         csr_acc;
   logic                         is_put;
   logic                         any_hit;
   logic [lkvc_pkg::VALUE_W-1:0] hit_value;
   lkvc_pkg::cell_ctrl_type      ctrl;
   lkvc_pkg::entry_type          chain [N];
   lkvc_pkg::entry_type          cells [N];
   logic [N:0]                   hits;
   logic [N-1:0]                 key_hits;
   logic [N-1:0]                 in_cap;
   logic [N-1:0]                 valids;

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid & csr_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_acc   = req_valid & req_ready;
   assign is_put    = (req_cmd == lkvc_pkg::CMD_PUT);
   assign any_hit   = hits[0];

   assign cap_in  = csr_acc ? csr_capacity_in_use : cap_ff;
   assign eff_cap = (lkvc_pkg::EFF_W'(cap_ff) > lkvc_pkg::EFF_W'(N)) ?
                    lkvc_pkg::EFF_W'(N) : lkvc_pkg::EFF_W'(cap_ff);

   always_comb begin
      hit_value = '0;
      for (int i = 0; i < N; i++) begin
         if (key_hits[i]) begin
            hit_value = hit_value | cells[i].value;
         end
      end
   end

   assign ctrl.clear   = csr_acc;
   assign ctrl.hit_upd = req_acc && any_hit;
   assign ctrl.ins_upd = req_acc && is_put && !any_hit;
   assign ctrl.key     = req_key;

   assign chain[0].valid = 1'b1;
   assign chain[0].key   = req_key;
   assign chain[0].value = is_put ? req_value : hit_value;
   assign hits[N]        = 1'b0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign in_cap[i] = lkvc_pkg::EFF_W'(i) < eff_cap;
      lkvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl_i     (ctrl),
         .in_cap_i   (in_cap[i]),
         .prev_i     (chain[i]),
         .tail_hit_i (hits[i+1]),
         .entry_o    (cells[i]),
         .match_o    (key_hits[i]),
         .hit_o      (hits[i])
      );
      if (i + 1 < N) begin : g_link
         assign chain[i+1] = cells[i];
      end
      assign valids[i]  = cells[i].valid;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_acc && !is_put) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = any_hit;
         rsp_value_in = any_hit ? hit_value : lkvc_pkg::MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lkvc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = signed'(rsp_value_ff);

   `LKVC_ASSERT(a_get_gives_result, clock, reset,
      (req_acc && !is_put) |=> rsp_valid_ff)
   `LKVC_ASSERT(a_put_gives_none, clock, reset,
      (req_acc && is_put) |=> !rsp_valid_ff)
   `LKVC_ASSERT(a_miss_value, clock, reset,
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_value_ff == lkvc_pkg::MISS_VALUE))
   `LKVC_ASSERT(a_csr_empties, clock, reset,
      csr_acc |=> ($countones(valids) == 0))
   `LKVC_ASSERT(a_occupancy_in_cap, clock, reset,
      lkvc_pkg::EFF_W'($countones(valids)) <= eff_cap)

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru key-value cache testbench
// sends gets and puts under random idling on both sides, keeps a shadow copy
// of the cache to predict every lookup and compares the results in order
// ----------------------------------------------------------------------------
module tb;
   import lkvc_pkg::*;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 225;

   typedef struct {
      logic               found;
      logic [VALUE_W-1:0] value;
   } lookup_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   cmd_type            req_cmd = CMD_GET;
   logic [KEY_W-1:0]   req_key = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_read_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_capacity_in_use = CAP_RESET;

   lookup_type pending_lookups[$];
   int error_count = 0;
   int cycle_count = 0;
   int req_gap_max = 0;
   int rsp_gap_max = 0;
   int rsp_wait = 0;
   int rsp_hold = 0;

   // shadow copy of the cache
   logic [KEY_W-1:0]   shadow_key   [CACHE_ENTRIES];
   logic [VALUE_W-1:0] shadow_value [CACHE_ENTRIES];
   bit                 shadow_valid [CACHE_ENTRIES];
   int unsigned        shadow_rank  [CACHE_ENTRIES];
   int unsigned        shadow_count;
   int unsigned        shadow_limit;

   lru_key_value_cache_core uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void shadow_clear();
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      shadow_count = 0;
   endfunction

   function automatic int shadow_find(logic [KEY_W-1:0] k);
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         if (shadow_valid[i] && shadow_key[i] == k)
            return i;
      end
      return -1;
   endfunction

   // entries more recent than idx age by one
   function automatic void shadow_promote(int idx);
      int unsigned r;
      r = shadow_rank[idx];
      for (int j = 0; j < CACHE_ENTRIES; j++) begin
         if (shadow_valid[j] && shadow_rank[j] < r)
            shadow_rank[j]++;
      end
      shadow_rank[idx] = 0;
   endfunction

   function automatic void shadow_insert(logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      int victim;
      int slot;
      victim = -1;
      slot = -1;
      if (shadow_count >= shadow_limit) begin
         for (int j = 0; j < CACHE_ENTRIES; j++) begin
            if (shadow_valid[j] && (victim < 0 || shadow_rank[j] > shadow_rank[victim]))
               victim = j;
         end
         if (victim >= 0) begin
            shadow_valid[victim] = 1'b0;
            shadow_rank[victim] = 0;
            shadow_count--;
         end
      end
      for (int j = 0; j < CACHE_ENTRIES; j++) begin
         if (!shadow_valid[j] && slot < 0)
            slot = j;
      end
      if (slot < 0)
         return;
      for (int j = 0; j < CACHE_ENTRIES; j++) begin
         if (shadow_valid[j])
            shadow_rank[j]++;
      end
      shadow_key[slot] = k;
      shadow_value[slot] = v;
      shadow_valid[slot] = 1'b1;
      shadow_rank[slot] = 0;
      shadow_count++;
   endfunction

   function automatic void predict_item(cmd_type cmd, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v);
      int idx;
      lookup_type res;
      idx = shadow_find(k);
      if (cmd == CMD_GET) begin
         if (idx >= 0) begin
            shadow_promote(idx);
            res.found = 1'b1;
            res.value = shadow_value[idx];
         end else begin
            res.found = 1'b0;
            res.value = MISS_VALUE;
         end
         pending_lookups.push_back(res);
      end else if (shadow_limit != 0) begin
         if (idx >= 0) begin
            shadow_value[idx] = v;
            shadow_promote(idx);
         end else begin
            shadow_insert(k, v);
         end
      end
   endfunction

   function automatic int draw_gap_limit();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 3;
         default: return 16;
      endcase
   endfunction

   task automatic send_item(cmd_type cmd, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      predict_item(cmd, k, v);
   endtask

   // a put may still be in flight after the last lookup came back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_idle();
      csr_valid <= 1'b1;
      csr_capacity_in_use <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_limit = (cap > CACHE_ENTRIES) ? CACHE_ENTRIES : cap;
      shadow_clear();
   endtask

   task automatic test_lookup_extremes();
      send_item(CMD_GET, 32'h8000_0000, 32'h0);
      send_item(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0);
      send_item(CMD_GET, 32'h0000_0000, 32'h0);
      send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
      send_item(CMD_GET, 32'h0000_0000, 32'h0);
   endtask

   task automatic test_lru_eviction();
      write_capacity(2);
      send_item(CMD_PUT, 32'd1, 32'd10);
      send_item(CMD_PUT, 32'd2, 32'd20);
      send_item(CMD_GET, 32'd1, 32'd0);
      send_item(CMD_PUT, 32'd3, 32'd30);
      send_item(CMD_GET, 32'd2, 32'd0);
      send_item(CMD_GET, 32'd1, 32'd0);
      send_item(CMD_GET, 32'd3, 32'd0);
   endtask

   task automatic test_zero_capacity();
      write_capacity(0);
      send_item(CMD_PUT, 32'd5, 32'd50);
      send_item(CMD_GET, 32'd5, 32'd0);
   endtask

   task automatic test_capacity_saturation();
      write_capacity(31);
      send_item(CMD_PUT, 32'd7, 32'd70);
      send_item(CMD_GET, 32'd7, 32'd0);
   endtask

   // a key pool slightly larger than the capacity keeps hits, misses and
   // evictions all frequent
   task automatic test_random_traffic(logic [CAP_W-1:0] cap, int count);
      logic [KEY_W-1:0] pool[$];
      int pool_size;
      logic [KEY_W-1:0] k;
      cmd_type cmd;
      write_capacity(cap);
      pool_size = ((cap > CACHE_ENTRIES) ? CACHE_ENTRIES : cap) + 4;
      for (int i = 0; i < pool_size; i++)
         pool.push_back($urandom);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) begin
            req_gap_max = draw_gap_limit();
            rsp_gap_max = draw_gap_limit();
         end
         if ($urandom_range(0, 9) == 0)
            k = $urandom;
         else
            k = pool[$urandom_range(0, pool_size - 1)];
         cmd = cmd_type'($urandom_range(0, 1));
         send_item(cmd, k, $urandom);
      end
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      logic [KEY_W-1:0] pool[$];
      cmd_type cmd;
      write_capacity(4);
      for (int i = 0; i < 6; i++)
         pool.push_back($urandom);
      req_gap_max = 0;
      rsp_gap_max = 0;
      rsp_hold = HOLD_CYCLES;
      for (int i = 0; i < 60; i++) begin
         cmd = ($urandom_range(0, 3) == 0) ? CMD_PUT : CMD_GET;
         send_item(cmd, pool[$urandom_range(0, 5)], $urandom);
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         rsp_wait = $urandom_range(0, rsp_gap_max);
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_lookup
      lookup_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, expected none, actual found %0b value %h",
                     $time, rsp_found, rsp_read_value);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found) begin
               error_count++;
               $display("%0t: found mismatch, expected %0b, actual %0b",
                        $time, want.found, rsp_found);
            end
            if (rsp_read_value !== want.value) begin
               error_count++;
               $display("%0t: read_value mismatch, expected %h, actual %h",
                        $time, want.value, rsp_read_value);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      shadow_limit = CACHE_ENTRIES;
      shadow_clear();
      req_gap_max = draw_gap_limit();
      rsp_gap_max = draw_gap_limit();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_lookup_extremes();
      test_lru_eviction();
      test_zero_capacity();
      test_capacity_saturation();
      test_random_traffic(16, PHASE_ITEMS);
      test_random_traffic(1, PHASE_ITEMS);
      test_random_traffic(2, PHASE_ITEMS);
      test_random_traffic(8, PHASE_ITEMS);
      test_random_traffic(31, PHASE_ITEMS);
      test_random_traffic(0, PHASE_ITEMS);
      test_random_traffic(17, PHASE_ITEMS);
      test_random_traffic(5, PHASE_ITEMS);
      test_backpressure();
      wait_idle();
      if (pending_lookups.size() != 0) begin
         error_count++;
         $display("%0t: %0d lookups never returned", $time, pending_lookups.size());
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
